// ----- sv/mfbr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the MSB-first bit reader.
package mfbr_pkg;

  localparam int DATA_W     = 32;
  localparam int POS_W      = 32;
  localparam int SHIFT_W    = $clog2(DATA_W);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [FIFO_AW:0] FIFO_FULL = (FIFO_AW + 1)'(FIFO_DEPTH);
  localparam logic [FIFO_AW:0] FIFO_ONE  = (FIFO_AW + 1)'(1);

  localparam logic [2:0] ACT_SUPPLY = 3'd0;
  localparam logic [2:0] ACT_FETCH  = 3'd1;
  localparam logic [2:0] ACT_ALIGN  = 3'd2;
  localparam logic [2:0] ACT_SKIP   = 3'd3;
  localparam logic [2:0] ACT_END    = 3'd4;

  localparam logic [7:0] FILL_BYTE = 8'hff;

  typedef enum logic [2:0] {
    CMD_SUPPLY,
    CMD_FETCH,
    CMD_ALIGN,
    CMD_SKIP,
    CMD_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  byte_value;
    logic [31:0] bit_count;
  } cmd_t;

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_FETCH,
    PEND_SKIP
  } pend_t;

  typedef enum logic {
    BK_IDLE,
    BK_SETTLE
  } bk_state_t;

  typedef struct packed {
    logic settle;
    logic pending;
    logic ended;
    logic error;
  } bk_status_t;

endpackage

// ----- sv/mfbr_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts transactions, decodes the action and queues commands.
module mfbr_front import mfbr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  action,
  input  logic [7:0]  byte_value,
  input  logic [31:0] bit_count,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  cmd_t               slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   fill;
  logic               known;
  cmd_kind_t          kind;
  logic               push;
  logic               pop;

  always_comb begin
    known = 1'b1;
    kind  = CMD_SUPPLY;
    case (action)
      ACT_SUPPLY: kind = CMD_SUPPLY;
      ACT_FETCH:  kind = CMD_FETCH;
      ACT_ALIGN:  kind = CMD_ALIGN;
      ACT_SKIP:   kind = CMD_SKIP;
      ACT_END:    kind = CMD_END;
      default:    known = 1'b0;
    endcase
  end

  assign req_stall = (fill == FIFO_FULL);
  assign push      = req_valid && !req_stall && known;
  assign cmd_valid = (fill != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + FIFO_ONE;
      end else if (pop && !push) begin
        fill <= fill - FIFO_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{kind: kind, byte_value: byte_value, bit_count: bit_count};
    end
  end

endmodule

// ----- sv/mfbr_back.sv -----
`timescale 1ns / 1ps
// Back end: carries out queued commands on the bit position and drives the result register.
module mfbr_back import mfbr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_t              cmd,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [DATA_W-1:0] field_value,
  output logic              overrun,
  output logic [POS_W-1:0]  byte_position,
  output logic [2:0]        bit_position,
  output bk_status_t        status
);

  bk_state_t         state, state_next;
  logic [7:0]        cur_byte, cur_byte_next;
  logic [2:0]        bit_off, bit_off_next;
  logic [POS_W-1:0]  byte_cnt, byte_cnt_next;
  logic [DATA_W-1:0] acc, acc_next;
  pend_t             pending, pending_next;
  logic [31:0]       bits_rem, bits_rem_next;
  logic              ended, ended_next;
  logic              err, err_next;
  logic              res_valid_next;
  logic [DATA_W-1:0] field_value_next;
  logic              overrun_next;
  logic [POS_W-1:0]  byte_position_next;
  logic [2:0]        bit_position_next;

  logic              is_supply;
  logic [7:0]        src;
  logic [2:0]        off_s;
  logic [31:0]       rem_s;
  logic [DATA_W-1:0] acc_s;
  logic              take_en;
  logic [3:0]        avail;
  logic [3:0]        take_n;
  logic [7:0]        aligned;
  logic [7:0]        bits;
  logic [3:0]        off_sum;
  logic [DATA_W-1:0] acc_take;
  logic [31:0]       rem_take;

  logic              fill_en;
  logic [SHIFT_W-1:0] r_sh;
  logic [DATA_W-1:0] acc_fill;
  logic [POS_W-1:0]  cnt_fill;

  always_comb begin
    is_supply = (cmd.kind == CMD_SUPPLY);
    src       = is_supply ? cmd.byte_value : cur_byte;
    off_s     = is_supply ? 3'd0 : bit_off;
    rem_s     = is_supply ? bits_rem : cmd.bit_count;
    acc_s     = (cmd.kind == CMD_FETCH) ? '0 : acc;
    take_en   = is_supply || (bit_off != 3'd0);
    avail     = 4'd8 - {1'b0, off_s};
    take_n    = take_en ? ((rem_s < 32'(avail)) ? rem_s[3:0] : avail) : 4'd0;
    aligned   = src << off_s;
    bits      = aligned >> (4'd8 - take_n);
    acc_take  = (acc_s << take_n) | DATA_W'(bits);
    off_sum   = {1'b0, off_s} + take_n;
    rem_take  = rem_s - 32'(take_n);
  end

  always_comb begin
    fill_en  = (bits_rem != '0) && (ended || err);
    r_sh     = bits_rem[SHIFT_W-1:0];
    acc_fill = (bits_rem >= 32'(DATA_W)) ? '1 : ((acc << r_sh) | ~({DATA_W{1'b1}} << r_sh));
    cnt_fill = byte_cnt + POS_W'(bits_rem >> 3);
  end

  always_comb begin
    state_next         = state;
    cur_byte_next      = cur_byte;
    bit_off_next       = bit_off;
    byte_cnt_next      = byte_cnt;
    acc_next           = acc;
    pending_next       = pending;
    bits_rem_next      = bits_rem;
    ended_next         = ended;
    err_next           = err;
    res_valid_next     = res_valid && res_stall;
    field_value_next   = field_value;
    overrun_next       = overrun;
    byte_position_next = byte_position;
    bit_position_next  = bit_position;
    cmd_ready          = (state == BK_IDLE);

    case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            CMD_SUPPLY: begin
              if (pending != PEND_NONE) begin
                cur_byte_next = cmd.byte_value;
                state_next    = BK_SETTLE;
              end
            end
            CMD_FETCH: begin
              if (pending == PEND_NONE) begin
                pending_next = PEND_FETCH;
                state_next   = BK_SETTLE;
              end
            end
            CMD_SKIP: begin
              if (pending == PEND_NONE && !err && cmd.bit_count != '0) begin
                pending_next = PEND_SKIP;
                state_next   = BK_SETTLE;
              end
            end
            CMD_ALIGN: begin
              if (pending == PEND_NONE && bit_off != 3'd0) begin
                bit_off_next  = 3'd0;
                byte_cnt_next = byte_cnt + POS_W'(1);
              end
            end
            CMD_END: begin
              ended_next = 1'b1;
              if (pending != PEND_NONE) begin
                state_next = BK_SETTLE;
              end
            end
            default: begin
            end
          endcase
          if (state_next == BK_SETTLE && cmd.kind != CMD_END) begin
            acc_next      = acc_take;
            bits_rem_next = rem_take;
            bit_off_next  = off_sum[3] ? 3'd0 : off_sum[2:0];
            byte_cnt_next = off_sum[3] ? byte_cnt + POS_W'(1) : byte_cnt;
          end
        end
      end
      BK_SETTLE: begin
        if (!(res_valid && res_stall)) begin
          state_next = BK_IDLE;
          if (fill_en) begin
            err_next      = 1'b1;
            acc_next      = acc_fill;
            byte_cnt_next = cnt_fill;
            bit_off_next  = bits_rem[2:0];
            cur_byte_next = FILL_BYTE;
            bits_rem_next = '0;
          end
          if (fill_en || bits_rem == '0) begin
            pending_next = PEND_NONE;
            if (pending == PEND_FETCH) begin
              res_valid_next     = 1'b1;
              field_value_next   = fill_en ? acc_fill : acc;
              overrun_next       = fill_en || err;
              byte_position_next = fill_en ? cnt_fill : byte_cnt;
              bit_position_next  = fill_en ? bits_rem[2:0] : bit_off;
            end
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      cur_byte  <= '0;
      bit_off   <= '0;
      byte_cnt  <= '0;
      acc       <= '0;
      pending   <= PEND_NONE;
      bits_rem  <= '0;
      ended     <= 1'b0;
      err       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cur_byte  <= cur_byte_next;
      bit_off   <= bit_off_next;
      byte_cnt  <= byte_cnt_next;
      acc       <= acc_next;
      pending   <= pending_next;
      bits_rem  <= bits_rem_next;
      ended     <= ended_next;
      err       <= err_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    field_value   <= field_value_next;
    overrun       <= overrun_next;
    byte_position <= byte_position_next;
    bit_position  <= bit_position_next;
  end

  assign status = '{settle:  (state == BK_SETTLE),
                    pending: (pending != PEND_NONE),
                    ended:   ended,
                    error:   err};

endmodule

// ----- sv/msb_first_bit_reader.sv -----
`timescale 1ns / 1ps
// Top level of the MSB-first bit reader: front decoder and queue, back executor.
//
//   channel   direction  handshake              payload
//   request   into       req_valid / req_stall  action, byte_value, bit_count
//   result    out of     res_valid / res_stall  field_value, overrun,
//                                               byte_position, bit_position
//
// A request transaction enters a four-entry command queue in the cycle it is accepted.
// The back end takes one command per cycle while idle; a command that moves bits
// (supply to a waiting request, fetch, skip, end of input with a request waiting)
// runs a take step, then a fill and finish step, taking no new command meanwhile. A
// fetch result is registered and shows in the cycle after the finish step. Reset
// empties the queue and clears control state, not the result data registers. A
// stalled result holds the back end in its finish step; a full queue stalls requests.
module msb_first_bit_reader import mfbr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [2:0]        action,
  input  logic [7:0]        byte_value,
  input  logic [31:0]       bit_count,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [DATA_W-1:0] field_value,
  output logic              overrun,
  output logic [POS_W-1:0]  byte_position,
  output logic [2:0]        bit_position
);

  logic       cmd_valid;
  logic       cmd_ready;
  cmd_t       cmd;
  bk_status_t status;

  mfbr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .action     (action),
    .byte_value (byte_value),
    .bit_count  (bit_count),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  mfbr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .field_value   (field_value),
    .overrun       (overrun),
    .byte_position (byte_position),
    .bit_position  (bit_position),
    .status        (status)
  );

  a_settle_pending: assert property (@(posedge clk) disable iff (rst)
    status.settle |-> status.pending)
    else $error("finish step without a waiting request");

  a_error_after_end: assert property (@(posedge clk) disable iff (rst)
    status.error |-> status.ended)
    else $error("error flag raised before end of input");

  a_result_from_settle: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(status.settle))
    else $error("result appeared without a finish step");

  a_settle_leaves: assert property (@(posedge clk) disable iff (rst)
    status.settle && !(res_valid && res_stall) |=> !status.settle)
    else $error("finish step held without a stalled result");

endmodule
